@@ src/gk_pkg.sv @@
// Shared types, constants and elaboration-time helpers of the Gaussian kernel unit.
// Used by all kernel modules; no dependencies.
`default_nettype none

package gk_pkg;

	// Register map
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_SMOOTHING_LENGTH = 3'd0;
	localparam logic [31:0] SMOOTHING_LENGTH_RESET = 32'd65536;

	// Direction codes
	localparam logic [1:0] DIR_X      = 2'd0;
	localparam logic [1:0] DIR_Y      = 2'd1;
	localparam logic [1:0] DIR_Z      = 2'd2;
	localparam logic [1:0] DIR_UNUSED = 2'd3;

	// Arithmetic constants
	localparam int CUTOFF_UNITS = 3;
	localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
	localparam int NORM_NUM_W = 48;
	localparam logic [NORM_NUM_W-1:0] NORM_DIVIDEND = 48'd2423175810 << 16;
	localparam int EXP_FRAC_BITS = 16;
	localparam int E_W = 38;      // exponent argument, in support at most 27*2^32
	localparam int Q_W = 51;      // slope dividend and quotient, in support at most 3*2^49
	localparam int NUM_SHIFT = 49;

	// Per-item sideband that travels with the slope division
	typedef struct packed {
		logic        in_sup;
		logic        dir_ok;
		logic        neg;
		logic [6:0]  n;
		logic [32:0] x;
	} gk_side_t;

	// One result
	typedef struct packed {
		logic [31:0] kernel_weight;
		logic [31:0] kernel_slope;
		logic        in_support;
		logic        saturated;
	} gk_res_t;

	// 2^-(2^-j) in Q.32, by repeated integer square roots of 2^31
	function automatic logic [31:0] exp_root(input int j);
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		r = 64'd1 << 31;
		for (int k = 1; k <= EXP_FRAC_BITS; k++) begin
			if (k <= j) begin
				v = r << 32;
				res = '0;
				b = 64'd1 << 62;
				for (int i = 0; i < 32; i++) begin
					if (v >= res + b) begin
						v = v - (res + b);
						res = (res >> 1) + b;
					end else begin
						res = res >> 1;
					end
					b = b >> 2;
				end
				r = res;
			end
		end
		return r[31:0];
	endfunction

endpackage

`default_nettype wire

@@ src/gk_if.sv @@
// Request and result channel interfaces of the Gaussian kernel unit.
// Depends on gk_pkg for nothing but shares its field widths.
`default_nettype none

interface gk_in_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] sep_x;
	logic signed [15:0] sep_y;
	logic signed [15:0] sep_z;
	logic [1:0]        direction;

	modport source (output valid, sep_x, sep_y, sep_z, direction, input ready);
	modport sink (input valid, sep_x, sep_y, sep_z, direction, output ready);
endinterface

interface gk_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        kernel_weight;
	logic signed [31:0] kernel_slope;
	logic               in_support;
	logic               saturated;

	modport source (output valid, kernel_weight, kernel_slope, in_support, saturated,
		input ready);
	modport sink (input valid, kernel_weight, kernel_slope, in_support, saturated,
		output ready);
endinterface

`default_nettype wire

@@ src/gk_norm.sv @@
// Normalisation unit: recomputes (c/h)^D after reset and each smoothing length write.
// Bit-serial divider followed by a mulq sequenced on one 32x32 multiplier. Uses gk_pkg.
`default_nettype none

module gk_norm #(
	parameter int DIMENSIONS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] h,
	output logic             busy,
	output logic [63:0]      norm
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_MUL  = 2'd3;

	localparam int NW    = gk_pkg::NORM_NUM_W;
	localparam int CNT_W = $clog2(NW);
	localparam int ACC_W = 64 + NW;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       part_q;
	logic [1:0]       round_q;
	logic [31:0]      rem_q;
	logic [NW-1:0]    num_q;
	logic [63:0]      norm_q;
	logic [ACC_W-1:0] acc_q;

	logic [32:0]      trial;
	logic             take;
	logic [32:0]      diff;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      prod;
	logic [ACC_W-1:0] acc_nx;
	logic [63:0]      acc_sat;

	// One restoring division step
	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff  = trial - {1'b0, h};
		take  = (trial >= {1'b0, h});
	end

	// One partial product of mulq(norm, q)
	always_comb begin
		mul_a   = part_q[0] ? norm_q[63:32] : norm_q[31:0];
		mul_b   = part_q[1] ? 32'(num_q[NW-1:32]) : num_q[31:0];
		prod    = 64'(mul_a) * 64'(mul_b);
		acc_nx  = acc_q + (ACC_W'(prod) << (32 * (32'(part_q[0]) + 32'(part_q[1]))));
		acc_sat = (acc_nx[ACC_W-1:96] != '0) ? '1 : acc_nx[95:32];
	end

	// Sequence load, divide and multiply rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			part_q  <= '0;
			round_q <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NW - 1)) begin
						part_q  <= '0;
						round_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						round_q <= round_q + 1'b1;
						if (round_q == 2'(DIMENSIONS - 2)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				rem_q <= '0;
				num_q <= gk_pkg::NORM_DIVIDEND;
			end
			ST_DIV: begin
				rem_q <= take ? diff[31:0] : trial[31:0];
				num_q <= {num_q[NW-2:0], take};
				if (cnt_q == CNT_W'(NW - 1)) begin
					norm_q <= 64'({num_q[NW-2:0], take});
					acc_q  <= '0;
				end
			end
			ST_MUL: begin
				if (part_q == 2'd3) begin
					norm_q <= acc_sat;
					acc_q  <= '0;
				end else begin
					acc_q <= acc_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign norm = norm_q;

endmodule

`default_nettype wire

@@ src/gk_exp.sv @@
// Front pipeline: magnitudes, support test, sum of squares, log2 scaling and the
// sixteen-stage fractional power of two. Uses gk_pkg.
`default_nettype none

module gk_exp #(
	parameter int DIMENSIONS    = 3,
	parameter int SEP_FRAC_BITS = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic signed [15:0]       sep_x,
	input  wire logic signed [15:0]       sep_y,
	input  wire logic signed [15:0]       sep_z,
	input  wire logic [1:0]               direction,
	output logic                          out_valid,
	output logic [gk_pkg::Q_W-1:0]        out_num,
	output gk_pkg::gk_side_t              out_side
);

	localparam int QW  = gk_pkg::Q_W;
	localparam int EW  = gk_pkg::E_W;
	localparam int FB  = gk_pkg::EXP_FRAC_BITS;
	localparam int ESH = 32 - 2 * SEP_FRAC_BITS;
	localparam logic [31:0] LIM = 32'(gk_pkg::CUTOFF_UNITS) << SEP_FRAC_BITS;

	typedef struct packed {
		gk_pkg::gk_side_t side;
		logic [FB-1:0]    fb;
		logic [QW-1:0]    num;
	} exs_t;

	// Stage 1: request register
	logic signed [15:0] sep_s1 [3];
	logic [1:0]         dir_s1;
	logic               v_s1;

	// Stage 2: magnitudes and squares
	logic [15:0]   mag_c [3];
	logic [31:0]   sq_c [3];
	logic          sup_c;
	logic          dok_c;
	logic          neg_c;
	logic [15:0]   magd_c;
	logic [31:0]   sq_s2 [3];
	logic          sup_s2;
	logic          dok_s2;
	logic          neg_s2;
	logic [QW-1:0] num_s2;
	logic          v_s2;

	// Stage 3: scaled exponent argument
	logic [33:0]   sum_c;
	logic [EW-1:0] e_c;
	logic [EW-1:0] e_s3;
	logic          sup_s3;
	logic          dok_s3;
	logic          neg_s3;
	logic [QW-1:0] num_s3;
	logic          v_s3;

	// Stage 4 onward: power of two chain
	logic [70:0] t_c;
	exs_t        ex_s [FB+1];
	logic        vx_s [FB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s1[0] <= sep_x;
			sep_s1[1] <= sep_y;
			sep_s1[2] <= sep_z;
			dir_s1    <= direction;
		end
	end

	// Take magnitudes, test the cutoff, square
	always_comb begin
		sup_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = sep_s1[i][15] ? 16'(-sep_s1[i]) : 16'(sep_s1[i]);
			if (i < DIMENSIONS) begin
				sq_c[i] = 32'(mag_c[i]) * 32'(mag_c[i]);
				if (32'(mag_c[i]) > LIM) begin
					sup_c = 1'b0;
				end
			end else begin
				sq_c[i] = '0;
			end
		end
		if (dir_s1 == gk_pkg::DIR_UNUSED || 32'(dir_s1) >= DIMENSIONS) begin
			magd_c = '0;
			neg_c  = 1'b0;
		end else begin
			magd_c = mag_c[dir_s1];
			neg_c  = sep_s1[dir_s1][15];
		end
		dok_c = (magd_c != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2  <= sq_c;
			sup_s2 <= sup_c;
			dok_s2 <= dok_c;
			neg_s2 <= neg_c;
			num_s2 <= QW'(64'(magd_c) << (gk_pkg::NUM_SHIFT - SEP_FRAC_BITS));
		end
	end

	// Sum the squares and align to Q.32
	assign sum_c = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);

	generate
		if (ESH >= 0) begin : g_eup
			assign e_c = EW'(64'(sum_c) << ESH);
		end else begin : g_edn
			assign e_c = EW'(64'(sum_c) >> (-ESH));
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			e_s3   <= e_c;
			sup_s3 <= sup_s2;
			dok_s3 <= dok_s2;
			neg_s3 <= neg_s2;
			num_s3 <= num_s2;
		end
	end

	// Scale by log2(e): integer part is the shift, top fraction bits drive the chain
	assign t_c = 71'(e_s3) * 71'(gk_pkg::LOG2E_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_s[0] <= 1'b0;
		end else if (en) begin
			vx_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s[0].side.in_sup <= sup_s3;
			ex_s[0].side.dir_ok <= dok_s3;
			ex_s[0].side.neg    <= neg_s3;
			ex_s[0].side.n      <= t_c[70:64];
			ex_s[0].side.x      <= 33'h1_0000_0000;
			ex_s[0].fb          <= t_c[63:64-FB];
			ex_s[0].num         <= num_s3;
		end
	end

	// One multiply by 2^-(2^-j) per stage where that fraction bit is set
	generate
		for (genvar j = 1; j <= FB; j++) begin : g_pow
			localparam logic [31:0] ROOT = gk_pkg::exp_root(j);
			logic [64:0] p_c;
			exs_t        nx_c;

			always_comb begin
				p_c  = 65'(ex_s[j-1].side.x) * 65'(ROOT);
				nx_c = ex_s[j-1];
				if (ex_s[j-1].fb[FB-j]) begin
					nx_c.side.x = p_c[64:32];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vx_s[j] <= 1'b0;
				end else if (en) begin
					vx_s[j] <= vx_s[j-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					ex_s[j] <= nx_c;
				end
			end
		end
	endgenerate

	assign out_valid = vx_s[FB];
	assign out_num   = ex_s[FB].num;
	assign out_side  = ex_s[FB].side;

endmodule

`default_nettype wire

@@ src/gk_div.sv @@
// Pipelined restoring divider for the slope factor 2|s_dir|/h, one quotient bit a stage.
// Carries the kernel sideband alongside. Uses gk_pkg.
`default_nettype none

module gk_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [31:0]             h,
	input  wire logic                    in_valid,
	input  wire logic [gk_pkg::Q_W-1:0]  in_num,
	input  wire gk_pkg::gk_side_t        in_side,
	output logic                         out_valid,
	output logic [gk_pkg::Q_W-1:0]       out_quo,
	output gk_pkg::gk_side_t             out_side
);

	localparam int QW = gk_pkg::Q_W;

	logic [31:0]      rem_s  [QW];
	logic [QW-1:0]    quo_s  [QW];
	gk_pkg::gk_side_t side_s [QW];
	logic             v_s    [QW];

	generate
		for (genvar k = 0; k < QW; k++) begin : g_stage
			logic [31:0]      rem_in;
			logic [QW-1:0]    quo_in;
			gk_pkg::gk_side_t side_in;
			logic             v_in;
			logic [32:0]      trial;
			logic [32:0]      diff;
			logic             take;

			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign quo_in  = in_num;
				assign side_in = in_side;
				assign v_in    = in_valid;
			end else begin : g_next
				assign rem_in  = rem_s[k-1];
				assign quo_in  = quo_s[k-1];
				assign side_in = side_s[k-1];
				assign v_in    = v_s[k-1];
			end

			// Shift in the next dividend bit and subtract where it fits
			always_comb begin
				trial = {rem_in, quo_in[QW-1]};
				diff  = trial - {1'b0, h};
				take  = (trial >= {1'b0, h});
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= take ? diff[31:0] : trial[31:0];
					quo_s[k]  <= {quo_in[QW-2:0], take};
					side_s[k] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

`default_nettype wire

@@ src/sph_gaussian_kernel_unit.sv @@
// Gaussian SPH kernel unit: one request per cycle sustained while the output side does
// not stall and no normalisation runs, set by the fully pipelined datapath (20 front
// stages, 51 divider stages, 6 tail stages) that feeds the output register.
// After reset and after each smoothing length write the normalisation unit runs its load,
// divide and multiply steps with the request channel not ready.
// Reset is asynchronous and active low; smoothing length resets to 1.0.
`default_nettype none

module sph_gaussian_kernel_unit #(
	parameter int DIMENSIONS    = 3,
	parameter int SEP_FRAC_BITS = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	gk_in_if.sink                            in_ch,
	gk_out_if.source                         out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gk_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int QW = gk_pkg::Q_W;

	logic [31:0] h_q;
	logic [31:0] hdiv;
	logic        cfg_wr;
	logic        busy;
	logic [63:0] norm;
	logic        en;
	logic        acc_in;

	logic             xv;
	logic [QW-1:0]    xnum;
	gk_pkg::gk_side_t xside;
	logic             dv;
	logic [QW-1:0]    dquo;
	gk_pkg::gk_side_t dside;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == gk_pkg::REG_SMOOTHING_LENGTH);
	assign prdata = (paddr == gk_pkg::REG_SMOOTHING_LENGTH) ? h_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= gk_pkg::SMOOTHING_LENGTH_RESET;
		end else if (cfg_wr) begin
			h_q <= pwdata;
		end
	end

	assign hdiv = (h_q == '0) ? 32'd1 : h_q;

	gk_norm #(.DIMENSIONS(DIMENSIONS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.h      (hdiv),
		.busy   (busy),
		.norm   (norm)
	);

	// Pipeline advances while the skid stage is free
	logic            out_v_q;
	logic            skid_v_q;
	gk_pkg::gk_res_t out_q;
	gk_pkg::gk_res_t skid_q;

	assign en          = !skid_v_q;
	assign in_ch.ready = en && !busy;
	assign acc_in      = in_ch.valid && in_ch.ready;

	gk_exp #(.DIMENSIONS(DIMENSIONS), .SEP_FRAC_BITS(SEP_FRAC_BITS)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (acc_in),
		.sep_x     (in_ch.sep_x),
		.sep_y     (in_ch.sep_y),
		.sep_z     (in_ch.sep_z),
		.direction (in_ch.direction),
		.out_valid (xv),
		.out_num   (xnum),
		.out_side  (xside)
	);

	gk_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.h         (hdiv),
		.in_valid  (xv),
		.in_num    (xnum),
		.in_side   (xside),
		.out_valid (dv),
		.out_quo   (dquo),
		.out_side  (dside)
	);

	// Tail stage 1: partial products of norm * x
	logic [64:0]      nxh_s1;
	logic [64:0]      nxl_s1;
	logic [QW-1:0]    g_s1;
	gk_pkg::gk_side_t side_s1;
	// Tail stage 2: weight before the shift
	logic [97:0]      p_c;
	logic [63:0]      wpre_s2;
	logic [QW-1:0]    g_s2;
	gk_pkg::gk_side_t side_s2;
	// Tail stage 3: weight in Q.32 and its Q16.16 output
	logic [63:0]      w_c;
	logic [63:0]      w_s3;
	logic [31:0]      wout_s3;
	logic             wsat_s3;
	logic [QW-1:0]    g_s3;
	gk_pkg::gk_side_t side_s3;
	// Tail stage 4: partial products of g * w
	logic [50:0]      hh_s4;
	logic [50:0]      hl_s4;
	logic [63:0]      lh_s4;
	logic [63:0]      ll_s4;
	logic [31:0]      wout_s4;
	logic             wsat_s4;
	gk_pkg::gk_side_t side_s4;
	// Tail stage 5: slope magnitude
	logic [83:0]      mf_c;
	logic [63:0]      ms_c;
	logic [47:0]      m_s5;
	logic [31:0]      wout_s5;
	logic             wsat_s5;
	gk_pkg::gk_side_t side_s5;
	// Tail stage 6: final result
	gk_pkg::gk_res_t  res_c;
	gk_pkg::gk_res_t  res_s6;
	logic             ssat_c;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             v_s4;
	logic             v_s5;
	logic             v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Saturate the weight product and apply the integer shift
	always_comb begin
		p_c = {1'b0, nxh_s1, 32'b0} + 98'(nxl_s1);
		w_c = (side_s2.n[6]) ? '0 : (wpre_s2 >> side_s2.n[5:0]);
	end

	// Saturate the slope product
	always_comb begin
		mf_c = (84'(hh_s4) << 32) + 84'(hl_s4) + 84'(lh_s4) + 84'(ll_s4[63:32]);
		ms_c = (mf_c[83:64] != '0) ? '1 : mf_c[63:0];
	end

	// Sign, clamp and zero outside the support
	always_comb begin
		ssat_c = 1'b0;
		res_c.kernel_slope = '0;
		if (side_s5.dir_ok) begin
			if (side_s5.neg) begin
				if (m_s5 > 48'h7FFF_FFFF) begin
					res_c.kernel_slope = 32'h7FFF_FFFF;
					ssat_c = 1'b1;
				end else begin
					res_c.kernel_slope = m_s5[31:0];
				end
			end else begin
				if (m_s5 > 48'h8000_0000) begin
					res_c.kernel_slope = 32'h8000_0000;
					ssat_c = 1'b1;
				end else begin
					res_c.kernel_slope = -m_s5[31:0];
				end
			end
		end
		res_c.kernel_weight = wout_s5;
		res_c.in_support    = 1'b1;
		res_c.saturated     = wsat_s5 || ssat_c;
		if (!side_s5.in_sup) begin
			res_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxh_s1  <= 65'(norm[63:32]) * 65'(dside.x);
			nxl_s1  <= 65'(norm[31:0]) * 65'(dside.x);
			g_s1    <= dquo;
			side_s1 <= dside;

			wpre_s2 <= (p_c[97:96] != '0) ? '1 : p_c[95:32];
			g_s2    <= g_s1;
			side_s2 <= side_s1;

			w_s3    <= w_c;
			wout_s3 <= (w_c[63:48] != '0) ? '1 : w_c[47:16];
			wsat_s3 <= (w_c[63:48] != '0);
			g_s3    <= g_s2;
			side_s3 <= side_s2;

			hh_s4   <= 51'(g_s3[QW-1:32]) * 51'(w_s3[63:32]);
			hl_s4   <= 51'(g_s3[QW-1:32]) * 51'(w_s3[31:0]);
			lh_s4   <= 64'(g_s3[31:0]) * 64'(w_s3[63:32]);
			ll_s4   <= 64'(g_s3[31:0]) * 64'(w_s3[31:0]);
			wout_s4 <= wout_s3;
			wsat_s4 <= wsat_s3;
			side_s4 <= side_s3;

			m_s5    <= ms_c[63:16];
			wout_s5 <= wout_s4;
			wsat_s5 <= wsat_s4;
			side_s5 <= side_s4;

			res_s6  <= res_c;
		end
	end

	// Output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (v_s6) begin
				if (!out_v_q || out_ch.ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end else if (out_ch.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s6) begin
				if (!out_v_q || out_ch.ready) begin
					out_q <= res_s6;
				end else begin
					skid_q <= res_s6;
				end
			end
		end else if (out_ch.ready) begin
			out_q <= skid_q;
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.kernel_weight = out_q.kernel_weight;
	assign out_ch.kernel_slope  = out_q.kernel_slope;
	assign out_ch.in_support    = out_q.in_support;
	assign out_ch.saturated     = out_q.saturated;

	// The skid stage only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds a result with the output register empty");

	// A smoothing length write blocks requests while the norm is recomputed
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ch.ready)
		else $error("request accepted during normalisation recompute");

	// Results outside the support are all zero
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.in_support) |->
		(out_ch.kernel_weight == '0 && out_ch.kernel_slope == '0 && !out_ch.saturated))
		else $error("non-zero result outside the support");

endmodule

`default_nettype wire

@@ dv/tb_sph_gaussian_kernel_unit.sv @@
// Self-checking testbench of the Gaussian SPH kernel unit: streams separation requests,
// predicts each weight and slope in the bench and compares every result.
// Depends on gk_pkg, gk_if and sph_gaussian_kernel_unit.
`default_nettype none

module tb_sph_gaussian_kernel_unit;

	localparam int DIMS      = 3;
	localparam int FRAC      = 12;
	localparam int WD_LIMIT  = 5000;
	localparam logic [63:0] INV_SQRT_PI = 64'd2423175810;
	localparam logic [63:0] LOG2E       = 64'd6196328019;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [gk_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	gk_in_if  in_ch();
	gk_out_if out_ch();

	sph_gaussian_kernel_unit #(.DIMENSIONS(DIMS), .SEP_FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Bench copy of the configuration and the exp2 root table
	logic [31:0]     h_reg;
	logic [63:0]     exp_roots [1:16];
	gk_pkg::gk_res_t kernel_expected [$];
	int              errors;
	int              idle_cycles;
	int              stall_left;
	bit              quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor of a*b / 2^32, clamped to 64 bits
	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> 32;
		if (p[127:64] != 0)
			return ALL_ONES;
		return p[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Weight and slope of one pair under the current smoothing length
	function automatic gk_pkg::gk_res_t kernel_eval(input logic signed [15:0] sx,
		input logic signed [15:0] sy, input logic signed [15:0] sz, input logic [1:0] dir);
		gk_pkg::gk_res_t r;
		logic [63:0] mag [3];
		logic signed [16:0] sv [3];
		logic [63:0] sum, e, t, n, x, h, q, nrm, w, wout, g, m;
		logic [15:0] fb;
		logic        sat;
		r = '0;
		sat = 1'b0;
		sv[0] = sx; sv[1] = sy; sv[2] = sz;
		sum = 0;
		for (int i = 0; i < 3; i++)
			mag[i] = (sv[i] < 0) ? 64'(-sv[i]) : 64'(sv[i]);
		for (int i = 0; i < DIMS; i++) begin
			if (mag[i] > (64'(gk_pkg::CUTOFF_UNITS) << FRAC))
				return r;
			sum += mag[i] * mag[i];
		end
		e = (2 * FRAC <= 32) ? (sum << (32 - 2 * FRAC)) : (sum >> (2 * FRAC - 32));
		t = mul_q32(e, LOG2E);
		n = t >> 32;
		fb = t[31:16];
		x = 64'd1 << 32;
		for (int j = 1; j <= 16; j++)
			if (fb[16 - j])
				x = (x * exp_roots[j]) >> 32;
		h = (h_reg == 0) ? 64'd1 : 64'(h_reg);
		q = (INV_SQRT_PI << 16) / h;
		nrm = q;
		for (int i = 1; i < DIMS; i++)
			nrm = mul_q32(nrm, q);
		w = mul_q32(nrm, x);
		w = (n >= 64) ? 64'd0 : (w >> n);
		wout = w >> 16;
		if (wout > 64'hFFFF_FFFF) begin
			wout = 64'hFFFF_FFFF;
			sat = 1'b1;
		end
		if (dir < DIMS && dir != gk_pkg::DIR_UNUSED && sv[dir] != 0) begin
			g = (mag[dir] << (49 - FRAC)) / h;
			m = mul_q32(g, w) >> 16;
			if (sv[dir] > 0) begin
				if (m > 64'h8000_0000) begin
					m = 64'h8000_0000;
					sat = 1'b1;
				end
				r.kernel_slope = 32'((64'd1 << 32) - m);
			end else begin
				if (m > 64'h7FFF_FFFF) begin
					m = 64'h7FFF_FFFF;
					sat = 1'b1;
				end
				r.kernel_slope = m[31:0];
			end
		end
		r.kernel_weight = wout[31:0];
		r.in_support = 1'b1;
		r.saturated = sat;
		return r;
	endfunction

	// Offer one request after a random gap; hold it until accepted
	task automatic send_pair(input logic [15:0] sx, input logic [15:0] sy,
		input logic [15:0] sz, input logic [1:0] dir);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.sep_x <= sx;
		in_ch.sep_y <= sy;
		in_ch.sep_z <= sz;
		in_ch.direction <= dir;
		do @(posedge clk); while (!in_ch.ready);
		kernel_expected.push_back(kernel_eval(sx, sy, sz, dir));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Wait for every result, then let the pipeline settle
	task automatic drain();
		drop_valid();
		while (kernel_expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_h(input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= gk_pkg::REG_SMOOTHING_LENGTH; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		h_reg = val;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		// read back
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== h_reg) begin
			$display("%0t smoothing_length read: expected %h actual %h", $time, h_reg, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	function automatic logic [15:0] rand_sep();
		if ($urandom_range(0, 3) != 0)
			return 16'($signed($urandom_range(0, 24576)) - 12288);
		return 16'($urandom());
	endfunction

	task automatic test_directed();
		logic [15:0] lim;
		lim = 16'(gk_pkg::CUTOFF_UNITS << FRAC);
		send_pair(0, 0, 0, gk_pkg::DIR_X);
		send_pair(lim, 0, 0, gk_pkg::DIR_X);
		send_pair(16'(-lim), 0, 0, gk_pkg::DIR_X);
		send_pair(16'(lim + 16'd1), 0, 0, gk_pkg::DIR_X);
		send_pair(0, 16'(-lim - 16'd1), 0, gk_pkg::DIR_Y);
		send_pair(0, 0, 16'(lim + 16'd1), gk_pkg::DIR_Z);
		send_pair(16'h8000, 0, 0, gk_pkg::DIR_X);
		send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, gk_pkg::DIR_Z);
		send_pair(lim, lim, lim, gk_pkg::DIR_Z);
		send_pair(16'(-lim), 16'(-lim), 16'(-lim), gk_pkg::DIR_Y);
		send_pair(16'd4096, 16'd2048, -16'd1024, gk_pkg::DIR_X);
		send_pair(16'd4096, 16'd2048, -16'd1024, gk_pkg::DIR_Y);
		send_pair(16'd4096, 16'd2048, -16'd1024, gk_pkg::DIR_Z);
		send_pair(16'd4096, 16'd2048, -16'd1024, gk_pkg::DIR_UNUSED);
		send_pair(0, 16'd100, 16'd100, gk_pkg::DIR_X);
		send_pair(16'd1, -16'd1, 16'd1, gk_pkg::DIR_Y);
		send_pair(-16'd1, 16'd1, -16'd1, gk_pkg::DIR_X);
		send_pair(16'd4, 16'd0, 16'd0, gk_pkg::DIR_X);
		drain();
	endtask

	task automatic test_random(input int count);
		repeat (count) begin
			quiet = ($urandom_range(0, 7) == 0);
			send_pair(rand_sep(), rand_sep(), rand_sep(), 2'($urandom_range(0, 3)));
		end
		quiet = 1'b0;
		drain();
	endtask

	// Hold the result side off so the pipeline fills and stalls the request side
	task automatic test_backpressure();
		stall_left = 400;
		quiet = 1'b1;
		repeat (150)
			send_pair(rand_sep(), rand_sep(), rand_sep(), 2'($urandom_range(0, 3)));
		quiet = 1'b0;
		drain();
		send_pair(16'd512, -16'd512, 16'd0, gk_pkg::DIR_X);
		drain();
	endtask

	task automatic test_settings();
		write_h(32'd1);
		test_random(40);
		write_h(32'd0);
		send_pair(16'd4096, 0, 0, gk_pkg::DIR_X);
		send_pair(-16'd4096, 0, 0, gk_pkg::DIR_X);
		test_random(20);
		write_h(32'hFFFF_FFFF);
		test_random(40);
		write_h(32'd256);
		test_random(40);
		write_h($urandom_range(16384, 1 << 20));
		test_random(80);
		write_h($urandom());
		test_random(40);
		write_h(gk_pkg::SMOOTHING_LENGTH_RESET);
	endtask

	// Result side: random stalls per result, plus the long hold-off
	initial begin
		int k;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			k = quiet ? 0 : $urandom_range(0, 19);
			if (k > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (k - 1) @(negedge clk);
			end
			while (stall_left > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk)
		if (stall_left > 0)
			stall_left <= stall_left - 1;

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		gk_pkg::gk_res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.kernel_weight, out_ch.kernel_slope, out_ch.in_support,
				out_ch.saturated};
			if (kernel_expected.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, got);
				errors++;
			end else begin
				want = kernel_expected.pop_front();
				if (got.kernel_weight !== want.kernel_weight) begin
					$display("%0t kernel_weight: expected %h actual %h", $time,
						want.kernel_weight, got.kernel_weight);
					errors++;
				end
				if (got.kernel_slope !== want.kernel_slope) begin
					$display("%0t kernel_slope: expected %h actual %h", $time,
						want.kernel_slope, got.kernel_slope);
					errors++;
				end
				if (got.in_support !== want.in_support) begin
					$display("%0t in_support: expected %b actual %b", $time,
						want.in_support, got.in_support);
					errors++;
				end
				if (got.saturated !== want.saturated) begin
					$display("%0t saturated: expected %b actual %b", $time,
						want.saturated, got.saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [63:0] r;
		errors = 0;
		idle_cycles = 0;
		stall_left = 0;
		quiet = 1'b0;
		h_reg = gk_pkg::SMOOTHING_LENGTH_RESET;
		r = 64'd1 << 31;
		for (int j = 1; j <= 16; j++) begin
			r = int_sqrt(r << 32);
			exp_roots[j] = r;
		end
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sep_x = '0; in_ch.sep_y = '0; in_ch.sep_z = '0;
		in_ch.direction = gk_pkg::DIR_X;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(50);
		test_backpressure();
		test_settings();
		test_random(20);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ sph_gaussian_kernel_unit.f @@
src/gk_pkg.sv
src/gk_if.sv
src/gk_norm.sv
src/gk_exp.sv
src/gk_div.sv
src/sph_gaussian_kernel_unit.sv
dv/tb_sph_gaussian_kernel_unit.sv
